// File: rtl/bqrc_pkg.sv
// ----------------------------------------------------------------------------
// bqrc_pkg: shared types and constants of the button qualifier
// Payload structs, configuration register indexes, chord phases and the
// control groups passed between the qualifier submodules.
// ----------------------------------------------------------------------------
package bqrc_pkg;

  localparam int unsigned NUM_BUTTONS  = 16;
  localparam int unsigned CHORD_WINDOW = 4;
  localparam int unsigned TIMER_W      = 8;
  localparam int unsigned HOLD_W       = 16;
  localparam int unsigned WIN_W        = 3;
  localparam int unsigned BIT_W        = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  typedef logic [NUM_BUTTONS-1:0] mask_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_DELAY     = 3'd0,
    CFG_REPEAT_PERIOD    = 3'd1,
    CFG_COOLDOWN_MASK    = 3'd2,
    CFG_COOLDOWN_FRAMES  = 3'd3,
    CFG_CHORD_FIRST_BIT  = 3'd4,
    CFG_CHORD_SECOND_BIT = 3'd5
  } cfg_idx_e;

  // chord tracking phases
  typedef enum logic [1:0] {
    CHORD_IDLE   = 2'd0,
    CHORD_FIRST  = 2'd1,
    CHORD_SECOND = 2'd2,
    CHORD_HELD   = 2'd3
  } chord_phase_e;

  typedef struct packed {
    logic [15:0] raw_buttons;
    logic        paused;
  } in_t;

  typedef struct packed {
    logic [15:0] held_mask;
    logic [15:0] press_mask;
    logic [15:0] release_mask;
    logic [15:0] repeat_mask;
    logic        chord_active;
    logic        chord_was_active;
  } out_t;

  typedef struct packed {
    logic [7:0]       repeat_delay;
    logic [7:0]       repeat_period;
    logic [15:0]      cooldown_mask;
    logic [7:0]       cooldown_frames;
    logic [BIT_W-1:0] chord_first_bit;
    logic [BIT_W-1:0] chord_second_bit;
  } cfg_t;

  // filtered masks of one frame plus the previous held mask
  typedef struct packed {
    mask_t prev_held;
    mask_t held;
    mask_t press;
    mask_t rel;
  } qual_t;

  typedef struct packed {
    logic active;
    logic was_active;
  } chord_t;

endpackage

// File: rtl/button_qualifier_repeat_chord.sv
// ----------------------------------------------------------------------------
// button_qualifier_repeat_chord: button qualifier with lockout, repeat, chord
// One frame of raw buttons in, one qualified result out per beat.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i/in_ready_o  | in_data_i  (bqrc_pkg::in_t)
//   out      | output    | out_valid_o/out_ready_i| out_data_o (bqrc_pkg::out_t)
//   cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// An input beat is registered, evaluated once the result register is free and
// registered as a result; one beat per cycle is sustained while the output is
// not stalled. The per-button timers all update in parallel in that evaluation.
// A stalled output holds its result; an empty input register takes a beat while
// the result waits. cfg is always ready. Reset clears the valid flags and the
// submodule state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module button_qualifier_repeat_chord (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bqrc_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bqrc_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bqrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bqrc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  bqrc_pkg::cfg_t   cfg_q;
  bqrc_pkg::in_t    in_q;
  logic             in_vld_q;
  bqrc_pkg::out_t   out_q;
  logic             out_vld_q;
  logic             adv;
  bqrc_pkg::qual_t  qual;
  bqrc_pkg::mask_t  rep;
  bqrc_pkg::chord_t chord;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_delay     <= 8'd10;
      cfg_q.repeat_period    <= 8'd4;
      cfg_q.cooldown_mask    <= 16'h0C00;
      cfg_q.cooldown_frames  <= 8'd6;
      cfg_q.chord_first_bit  <= 4'd11;
      cfg_q.chord_second_bit <= 4'd10;
    end else if (cfg_valid_i) begin
      case (bqrc_pkg::cfg_idx_e'(cfg_index_i))
        bqrc_pkg::CFG_REPEAT_DELAY:     cfg_q.repeat_delay     <= cfg_data_i[7:0];
        bqrc_pkg::CFG_REPEAT_PERIOD:    cfg_q.repeat_period    <= cfg_data_i[7:0];
        bqrc_pkg::CFG_COOLDOWN_MASK:    cfg_q.cooldown_mask    <= cfg_data_i;
        bqrc_pkg::CFG_COOLDOWN_FRAMES:  cfg_q.cooldown_frames  <= cfg_data_i[7:0];
        bqrc_pkg::CFG_CHORD_FIRST_BIT:  cfg_q.chord_first_bit  <= cfg_data_i[3:0];
        bqrc_pkg::CFG_CHORD_SECOND_BIT: cfg_q.chord_second_bit <= cfg_data_i[3:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // pipeline control: evaluate when a beat waits and the result slot frees
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  bqrc_lockout u_lockout (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .raw_i    (in_q.raw_buttons),
    .paused_i (in_q.paused),
    .cfg_i    (cfg_q),
    .qual_o   (qual)
  );

  bqrc_repeat u_repeat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .qual_i   (qual),
    .cfg_i    (cfg_q),
    .repeat_o (rep)
  );

  bqrc_chord u_chord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .qual_i  (qual),
    .cfg_i   (cfg_q),
    .chord_o (chord)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.held_mask        <= qual.held;
      out_q.press_mask       <= qual.press;
      out_q.release_mask     <= qual.rel;
      out_q.repeat_mask      <= rep;
      out_q.chord_active     <= chord.active;
      out_q.chord_was_active <= chord.was_active;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // checks
  a_press_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.press_mask & ~out_data_o.held_mask) == '0))
    else $error("press mask holds a button that is not held");

  a_release_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.release_mask & out_data_o.held_mask) == '0))
    else $error("release mask overlaps held mask");

  a_repeat_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.repeat_mask == '0 ||
                     out_data_o.repeat_mask == out_data_o.held_mask))
    else $error("repeat mask differs from held mask");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !adv) |=> !out_valid_o)
    else $error("result beat repeated after it was taken");

endmodule

// File: rtl/bqrc_lockout.sv
// ----------------------------------------------------------------------------
// bqrc_lockout: edge detect with per-button release lockout
// Compares the raw mask against the last held mask and masks out any button
// whose lockout timer runs; arms timers on release of cooldown buttons.
// ----------------------------------------------------------------------------
module bqrc_lockout (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  bqrc_pkg::mask_t              raw_i,
  input  logic                         paused_i,
  input  bqrc_pkg::cfg_t               cfg_i,
  output bqrc_pkg::qual_t              qual_o
);

  logic [bqrc_pkg::TIMER_W-1:0] timer_q [bqrc_pkg::NUM_BUTTONS];
  logic [bqrc_pkg::TIMER_W-1:0] timer_d [bqrc_pkg::NUM_BUTTONS];
  bqrc_pkg::mask_t prev_held_q;
  bqrc_pkg::mask_t rise, fall, held, press, rel;

  assign rise = raw_i & ~prev_held_q;
  assign fall = prev_held_q & ~raw_i;

  // per-button timer update and qualification
  always_comb begin
    held  = '0;
    press = '0;
    rel   = '0;
    for (int i = 0; i < bqrc_pkg::NUM_BUTTONS; i++) begin
      timer_d[i] = timer_q[i];
      if (timer_q[i] != '0) begin
        // running timer: count down, hold at one while still pressed
        if (!paused_i) begin
          if (timer_q[i] == bqrc_pkg::TIMER_W'(1) && raw_i[i]) begin
            timer_d[i] = bqrc_pkg::TIMER_W'(1);
          end else begin
            timer_d[i] = timer_q[i] - bqrc_pkg::TIMER_W'(1);
          end
        end
      end else begin
        held[i]  = raw_i[i];
        press[i] = rise[i];
        rel[i]   = fall[i];
        if (fall[i] && !paused_i) begin
          timer_d[i] = cfg_i.cooldown_mask[i] ? cfg_i.cooldown_frames : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_held_q <= '0;
      for (int i = 0; i < bqrc_pkg::NUM_BUTTONS; i++) begin
        timer_q[i] <= '0;
      end
    end else if (en_i) begin
      prev_held_q <= held;
      for (int i = 0; i < bqrc_pkg::NUM_BUTTONS; i++) begin
        timer_q[i] <= timer_d[i];
      end
    end
  end

  assign qual_o.prev_held = prev_held_q;
  assign qual_o.held      = held;
  assign qual_o.press     = press;
  assign qual_o.rel       = rel;

endmodule

// File: rtl/bqrc_repeat.sv
// ----------------------------------------------------------------------------
// bqrc_repeat: auto-repeat frame counter
// Counts frames with an unchanged held mask and pulses the held mask after
// the first delay and then once per repeat period.
// ----------------------------------------------------------------------------
module bqrc_repeat (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  bqrc_pkg::qual_t qual_i,
  input  bqrc_pkg::cfg_t  cfg_i,
  output bqrc_pkg::mask_t repeat_o
);

  logic [bqrc_pkg::HOLD_W-1:0] hold_q, hold_d;
  logic [bqrc_pkg::HOLD_W-1:0] hold_base, hold_inc;
  logic [8:0]                  delay_plus_period;

  // any press restarts the count
  assign hold_base = (|qual_i.press) ? '0 : hold_q;
  assign hold_inc  = hold_base + bqrc_pkg::HOLD_W'(1);
  assign delay_plus_period = {1'b0, cfg_i.repeat_delay} + {1'b0, cfg_i.repeat_period};

  always_comb begin
    hold_d   = hold_base;
    repeat_o = '0;
    if (qual_i.prev_held == qual_i.held) begin
      if (hold_inc == bqrc_pkg::HOLD_W'(cfg_i.repeat_delay) ||
          hold_inc == bqrc_pkg::HOLD_W'(delay_plus_period)) begin
        repeat_o = qual_i.held;
        hold_d   = bqrc_pkg::HOLD_W'(cfg_i.repeat_delay);
      end else begin
        hold_d = hold_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (en_i) begin
      hold_q <= hold_d;
    end
  end

endmodule

// File: rtl/bqrc_chord.sv
// ----------------------------------------------------------------------------
// bqrc_chord: two-button chord tracker
// Phase machine that sets the chord flag when both chord buttons go down
// within the window, clears it when both are up or a release times out.
// ----------------------------------------------------------------------------
module bqrc_chord (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  bqrc_pkg::qual_t qual_i,
  input  bqrc_pkg::cfg_t  cfg_i,
  output bqrc_pkg::chord_t chord_o
);

  bqrc_pkg::chord_phase_e     phase_q, phase_d;
  logic [bqrc_pkg::WIN_W-1:0] win_q, win_d, win_inc;
  logic                       flag_q, flag_d;
  logic                       win_end, in_window;
  bqrc_pkg::mask_t            fa, fb;
  logic                       pa, pb, ra, rb;

  assign fa = bqrc_pkg::mask_t'(1) << cfg_i.chord_first_bit;
  assign fb = bqrc_pkg::mask_t'(1) << cfg_i.chord_second_bit;
  assign pa = |(qual_i.press & fa);
  assign pb = |(qual_i.press & fb);
  assign ra = |(qual_i.rel & fa);
  assign rb = |(qual_i.rel & fb);

  assign win_inc   = win_q + bqrc_pkg::WIN_W'(1);
  assign win_end   = win_inc >= bqrc_pkg::WIN_W'(bqrc_pkg::CHORD_WINDOW);
  assign in_window = (phase_q == bqrc_pkg::CHORD_FIRST) ||
                     (phase_q == bqrc_pkg::CHORD_SECOND);

  // next state
  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    flag_d  = flag_q;
    if (!flag_q) begin
      case (phase_q)
        bqrc_pkg::CHORD_IDLE: begin
          if (pa && pb) begin
            phase_d = bqrc_pkg::CHORD_HELD;
            flag_d  = 1'b1;
          end else if (pa) begin
            phase_d = bqrc_pkg::CHORD_FIRST;
            win_d   = '0;
          end else if (pb) begin
            phase_d = bqrc_pkg::CHORD_SECOND;
            win_d   = '0;
          end
        end
        bqrc_pkg::CHORD_FIRST, bqrc_pkg::CHORD_SECOND: begin
          win_d = win_inc;
          if (win_end) begin
            phase_d = bqrc_pkg::CHORD_IDLE;
          end else if (pa || pb) begin
            phase_d = bqrc_pkg::CHORD_HELD;
            flag_d  = 1'b1;
          end
        end
        default: ;  // held without flag: no change
      endcase
    end else begin
      case (phase_q)
        bqrc_pkg::CHORD_HELD: begin
          if (ra && rb) begin
            phase_d = bqrc_pkg::CHORD_IDLE;
            flag_d  = 1'b0;
          end else if (ra) begin
            phase_d = bqrc_pkg::CHORD_SECOND;
            win_d   = '0;
          end else if (rb) begin
            phase_d = bqrc_pkg::CHORD_FIRST;
            win_d   = '0;
          end
        end
        bqrc_pkg::CHORD_FIRST, bqrc_pkg::CHORD_SECOND: begin
          win_d = win_inc;
          if (win_end || ra || rb) begin
            phase_d = bqrc_pkg::CHORD_IDLE;
            flag_d  = 1'b0;
          end
        end
        default: ;  // idle with flag: no change
      endcase
    end
  end

  // outputs: release timeout also drops the frame-start flag
  always_comb begin
    chord_o.active     = flag_d;
    chord_o.was_active = flag_q && !(in_window && win_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bqrc_pkg::CHORD_IDLE;
      win_q   <= '0;
      flag_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      flag_q  <= flag_d;
    end
  end

endmodule
